[sv/onewire_temperature_reader_defines.svh]
// Assertion macros for the one-wire temperature reader.
`ifndef ONEWIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONEWIRE_TEMPERATURE_READER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define OWTR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owtr assertion failed");
// Check that cons holds in the cycle after ante.
`define OWTR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owtr assertion failed");
`else
`define OWTR_ASSERT_SAME(lbl, ante, cons)
`define OWTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/owtr_pkg.sv]
// Shared types and constants for the one-wire temperature reader.
`default_nettype none
package owtr_pkg;
	localparam int CFG_W     = 20;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Configuration register indexes
	localparam reg_idx_t REG_RESET_LOW   = 3'd0;
	localparam reg_idx_t REG_PRESENCE    = 3'd1;
	localparam reg_idx_t REG_WRITE_LOW   = 3'd2;
	localparam reg_idx_t REG_WRITE_SLOT  = 3'd3;
	localparam reg_idx_t REG_READ_LOW    = 3'd4;
	localparam reg_idx_t REG_READ_SAMPLE = 3'd5;
	localparam reg_idx_t REG_RECOVERY    = 3'd6;
	localparam reg_idx_t REG_CONVERT     = 3'd7;

	// Byte sequence steps: 0..3 are command bytes, 4..5 scratchpad reads
	localparam logic [2:0] STEP_CONVERT_CMD = 3'd1;
	localparam logic [2:0] STEP_SECOND_RST  = 3'd2;
	localparam logic [2:0] STEP_FIRST_READ  = 3'd4;
	localparam logic [2:0] STEP_LAST_READ   = 3'd5;
	localparam logic [2:0] BIT_LAST         = 3'd7;

	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_WR_LOW   = 4'd3,
		PH_WR_HOLD  = 4'd4,
		PH_WR_REC   = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_WAIT  = 4'd7,
		PH_RD_REC   = 4'd8,
		PH_BYTE_REC = 4'd9,
		PH_CONV     = 4'd10
	} phase_t;

	// Timer control from the sequencer
	typedef struct packed {
		logic     run;
		reg_idx_t sel;
	} tmr_ctl_t;

	function automatic logic [CFG_W-1:0] reg_reset_value(input reg_idx_t idx);
		logic [CFG_W-1:0] v;
		case (idx)
			REG_RESET_LOW:   v = 20'd5000;
			REG_PRESENCE:    v = 20'd5000;
			REG_WRITE_LOW:   v = 20'd150;
			REG_WRITE_SLOT:  v = 20'd450;
			REG_READ_LOW:    v = 20'd10;
			REG_READ_SAMPLE: v = 20'd20;
			REG_RECOVERY:    v = 20'd400;
			REG_CONVERT:     v = 20'd1000000;
			default:         v = 20'd1;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] cmd_byte(input logic [1:0] step);
		logic [7:0] b;
		case (step)
			2'd0:    b = CMD_SKIP_ROM;
			2'd1:    b = CMD_CONVERT;
			2'd2:    b = CMD_SKIP_ROM;
			2'd3:    b = CMD_READ_PAD;
			default: b = CMD_SKIP_ROM;
		endcase
		return b;
	endfunction
endpackage
`default_nettype wire

[sv/owtr_regs.sv]
// Timing register file with write port and one selected read.
`default_nettype none
module owtr_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire owtr_pkg::reg_idx_t                cfg_index,
	input  wire logic [owtr_pkg::CFG_W-1:0]        cfg_data,
	input  wire owtr_pkg::reg_idx_t                sel,
	output logic [owtr_pkg::CFG_W-1:0]             sel_value
);
	logic [owtr_pkg::CFG_W-1:0] regs_q [owtr_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < owtr_pkg::NUM_REGS; i++) begin
				regs_q[i] <= owtr_pkg::reg_reset_value(owtr_pkg::REG_IDX_W'(i));
			end
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	assign sel_value = regs_q[sel];
endmodule
`default_nettype wire

[sv/owtr_timer.sv]
// Phase tick timer: counts ticks and flags the last tick of a phase.
`default_nettype none
module owtr_timer #(
	parameter int TIMER_BITS = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire owtr_pkg::tmr_ctl_t          ctl,
	input  wire logic [owtr_pkg::CFG_W-1:0]  dur_raw,
	output logic                             ended
);
	localparam int CW = ((TIMER_BITS > owtr_pkg::CFG_W) ? TIMER_BITS : owtr_pkg::CFG_W) + 1;
	localparam logic [CW-1:0] CAP = CW'((64'd1 << TIMER_BITS) - 64'd1);

	logic [TIMER_BITS-1:0] tick_q;
	logic [CW-1:0]         raw_ext;
	logic [CW-1:0]         dur;
	logic [CW-1:0]         tick_next;

	always_comb begin
		raw_ext = CW'(dur_raw);
		// zero acts as one, overlong is capped
		if (raw_ext == '0) begin
			dur = CW'(1);
		end else if (raw_ext > CAP) begin
			dur = CAP;
		end else begin
			dur = raw_ext;
		end
		tick_next = CW'(tick_q) + CW'(1);
		ended     = (tick_next >= dur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (ctl.run) begin
			tick_q <= ended ? '0 : tick_next[TIMER_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

[sv/owtr_seq.sv]
// Bus sequencer: phase machine, bit and byte counters, shift and held reading.
`default_nettype none
module owtr_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                start_req,
	input  wire logic                line_in,
	input  wire logic                ended,
	output owtr_pkg::tmr_ctl_t       tmr_ctl,
	output logic                     drive,
	output logic                     busy,
	output logic                     done,
	output logic [15:0]              held_next
);
	owtr_pkg::phase_t   phase_q, phase_n;
	logic [2:0]         bit_cnt_q, bit_n;
	logic [2:0]         byte_step_q, byte_n, byte_inc;
	logic [15:0]        shift_q, shift_n;
	logic [15:0]        held_q;
	logic [7:0]         cmd;
	owtr_pkg::reg_idx_t sel;

	// Register that times the current phase
	always_comb begin
		case (phase_q)
			owtr_pkg::PH_RST_LOW:  sel = owtr_pkg::REG_RESET_LOW;
			owtr_pkg::PH_RST_WAIT: sel = owtr_pkg::REG_PRESENCE;
			owtr_pkg::PH_WR_LOW:   sel = owtr_pkg::REG_WRITE_LOW;
			owtr_pkg::PH_WR_HOLD:  sel = owtr_pkg::REG_WRITE_SLOT;
			owtr_pkg::PH_RD_LOW:   sel = owtr_pkg::REG_READ_LOW;
			owtr_pkg::PH_RD_WAIT:  sel = owtr_pkg::REG_READ_SAMPLE;
			owtr_pkg::PH_CONV:     sel = owtr_pkg::REG_CONVERT;
			default:               sel = owtr_pkg::REG_RECOVERY;
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		bit_n     = bit_cnt_q;
		byte_n    = byte_step_q;
		byte_inc  = 3'(byte_step_q + 3'd1);
		shift_n   = shift_q;
		held_next = held_q;
		drive     = 1'b0;
		busy      = 1'b1;
		done      = 1'b0;
		cmd       = owtr_pkg::cmd_byte(byte_step_q[1:0]);
		case (phase_q)
			owtr_pkg::PH_RST_LOW: begin
				drive = 1'b1;
				if (ended) phase_n = owtr_pkg::PH_RST_WAIT;
			end
			owtr_pkg::PH_RST_WAIT: begin
				if (ended) begin
					bit_n   = '0;
					phase_n = (byte_step_q >= owtr_pkg::STEP_FIRST_READ) ?
						owtr_pkg::PH_RD_LOW : owtr_pkg::PH_WR_LOW;
				end
			end
			owtr_pkg::PH_WR_LOW: begin
				drive = 1'b1;
				if (ended) phase_n = owtr_pkg::PH_WR_HOLD;
			end
			owtr_pkg::PH_WR_HOLD: begin
				drive = ~cmd[bit_cnt_q];
				if (ended) phase_n = owtr_pkg::PH_WR_REC;
			end
			owtr_pkg::PH_RD_LOW: begin
				drive = 1'b1;
				if (ended) phase_n = owtr_pkg::PH_RD_WAIT;
			end
			owtr_pkg::PH_RD_WAIT: begin
				if (ended) begin
					shift_n = {line_in, shift_q[15:1]};
					phase_n = owtr_pkg::PH_RD_REC;
				end
			end
			owtr_pkg::PH_WR_REC, owtr_pkg::PH_RD_REC: begin
				if (ended) begin
					if (bit_cnt_q == owtr_pkg::BIT_LAST) begin
						phase_n = owtr_pkg::PH_BYTE_REC;
					end else begin
						bit_n   = 3'(bit_cnt_q + 3'd1);
						phase_n = (phase_q == owtr_pkg::PH_WR_REC) ?
							owtr_pkg::PH_WR_LOW : owtr_pkg::PH_RD_LOW;
					end
				end
			end
			owtr_pkg::PH_BYTE_REC: begin
				if (ended) begin
					if (byte_step_q == owtr_pkg::STEP_CONVERT_CMD) begin
						phase_n = owtr_pkg::PH_CONV;
					end else if (byte_step_q >= owtr_pkg::STEP_LAST_READ) begin
						held_next = shift_q;
						done      = 1'b1;
						byte_n    = '0;
						phase_n   = owtr_pkg::PH_IDLE;
					end else begin
						byte_n  = byte_inc;
						bit_n   = '0;
						phase_n = (byte_inc >= owtr_pkg::STEP_FIRST_READ) ?
							owtr_pkg::PH_RD_LOW : owtr_pkg::PH_WR_LOW;
					end
				end
			end
			owtr_pkg::PH_CONV: begin
				if (ended) begin
					byte_n  = owtr_pkg::STEP_SECOND_RST;
					phase_n = owtr_pkg::PH_RST_LOW;
				end
			end
			default: begin
				busy    = 1'b0;
				phase_n = owtr_pkg::PH_IDLE;
				if (start_req) begin
					byte_n  = '0;
					bit_n   = '0;
					shift_n = '0;
					phase_n = owtr_pkg::PH_RST_LOW;
				end
			end
		endcase
	end

	assign tmr_ctl.run = adv & busy;
	assign tmr_ctl.sel = sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= owtr_pkg::PH_IDLE;
			bit_cnt_q   <= '0;
			byte_step_q <= '0;
			shift_q     <= '0;
			held_q      <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			bit_cnt_q   <= bit_n;
			byte_step_q <= byte_n;
			shift_q     <= shift_n;
			held_q      <= held_next;
		end
	end
endmodule
`default_nettype wire

[sv/owtr_temp.sv]
// Reading to whole degrees, truncated toward zero.
`default_nettype none
module owtr_temp (
	input  wire logic signed [15:0] raw,
	output logic signed [11:0]      whole
);
	logic signed [16:0] biased;

	// bias negatives by 15 so the arithmetic shift truncates toward zero
	assign biased = $signed({raw[15], raw}) + (raw[15] ? 17'sd15 : 17'sd0);
	assign whole  = biased[15:4];
endmodule
`default_nettype wire

[sv/onewire_temperature_reader.sv]
// Top level: one-wire bus master running a fixed temperature read sequence.
// The result for an item appears in the output register in the cycle after acceptance.
// One item per cycle unless out_ready stalls; one output register, refilled as it drains.
// Each item advances the phase machine, and the timer when busy, by exactly one bus tick.
// Reset (arst_n low, asynchronous): idle phase, timer and counters cleared, reading zero,
// timing registers at their defaults, output register empty.
`include "onewire_temperature_reader_defines.svh"
`default_nettype none
module onewire_temperature_reader #(
	parameter int TIMER_BITS = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write port
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [19:0]                 cfg_data,
	// input channel: one bus tick per item
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        start_req,
	input  wire logic                        line_in,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             drive_low,
	output logic                             busy_res,
	output logic                             done_res,
	output logic signed [15:0]               raw_reading,
	output logic signed [11:0]               whole_degrees
);
	logic                             adv;
	logic                             ended;
	logic                             drive;
	logic                             busy;
	logic                             done;
	logic [15:0]                      held_next;
	logic signed [11:0]               whole_next;
	logic [owtr_pkg::CFG_W-1:0]       dur_raw;
	owtr_pkg::tmr_ctl_t               tmr_ctl;

	logic                             out_valid_q;
	logic                             drive_q;
	logic                             busy_q;
	logic                             done_q;
	logic [15:0]                      raw_q;
	logic signed [11:0]               whole_q;

	// Take an item whenever the result register is empty or being drained.
	assign in_ready = ~out_valid_q | out_ready;
	assign adv      = in_valid & in_ready;

	owtr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel       (tmr_ctl.sel),
		.sel_value (dur_raw)
	);

	owtr_timer #(
		.TIMER_BITS (TIMER_BITS)
	) u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tmr_ctl),
		.dur_raw (dur_raw),
		.ended   (ended)
	);

	owtr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start_req (start_req),
		.line_in   (line_in),
		.ended     (ended),
		.tmr_ctl   (tmr_ctl),
		.drive     (drive),
		.busy      (busy),
		.done      (done),
		.held_next (held_next)
	);

	// Degrees follow the reading as it stands after this tick.
	owtr_temp u_temp (
		.raw   ($signed(held_next)),
		.whole (whole_next)
	);

	// Result register: load on every accepted item, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= drive;
			busy_q  <= busy;
			done_q  <= done;
			raw_q   <= held_next;
			whole_q <= whole_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_low     = drive_q;
	assign busy_res      = busy_q;
	assign done_res      = done_q;
	assign raw_reading   = $signed(raw_q);
	assign whole_degrees = whole_q;

	// Every accepted item leaves a result behind.
	`OWTR_ASSERT_NEXT(a_item_gives_result, adv, out_valid)
	// A done pulse only ends a running sequence.
	`OWTR_ASSERT_SAME(a_done_in_busy, out_valid && done_res, busy_res)
	// The line is only pulled low inside a sequence.
	`OWTR_ASSERT_SAME(a_drive_in_busy, out_valid && drive_low, busy_res)
endmodule
`default_nettype wire
